// ----- hdl/tgfq_pkg.sv -----
`default_nettype none
package tgfq_pkg;
	localparam int MAX_TEAMS_D   = 64;
	localparam int MAX_MEMBERS_D = 1024;
	localparam int SLOTS_D       = 1024;
	localparam int KIND_W   = 2;
	localparam int MEMBER_W = 10;
	localparam int TEAM_W   = 6;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [MEMBER_W-1:0] member;
		logic [STATUS_W-1:0] status;
	} result_t;
endpackage
`default_nettype wire

// ----- hdl/tgfq_core.sv -----
`default_nettype none
module tgfq_core
	import tgfq_pkg::*;
#(
	parameter int MAX_TEAMS   = MAX_TEAMS_D,
	parameter int MAX_MEMBERS = MAX_MEMBERS_D,
	parameter int SLOTS       = SLOTS_D
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [MEMBER_W-1:0] member_id,
	input  wire logic [TEAM_W-1:0]   team_id,
	output logic                     busy,
	output logic                     done,
	output result_t                  res
);
	localparam int TW = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;
	localparam int MW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int OW = $clog2(MAX_TEAMS + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_RD2  = 6'b000100,
		S_RD3  = 6'b001000,
		S_RD4  = 6'b010000,
		S_WR   = 6'b100000
	} state_t;
	state_t state_q;

	// member table, cleared by sweep after reset
	logic [TW-1:0] mteam_mem [MAX_MEMBERS];
	logic [TW-1:0] ring_mem [MAX_TEAMS];
	logic [SW-1:0] thead_mem [MAX_TEAMS];
	logic [SW-1:0] ttail_mem [MAX_TEAMS];
	logic [MW-1:0] smem_mem [SLOTS];
	logic [SW-1:0] slink_mem [SLOTS];
	logic [SW-1:0] free_mem [SLOTS];
	logic [MAX_TEAMS-1:0] nonempty_q;

	logic [MW:0]   clr_q;
	logic          clr_done;
	logic [CW-1:0] used_q;
	logic [CW-1:0] freeinit_q;
	logic [TW-1:0] ohead_q, otail_q;
	logic [OW-1:0] ocnt_q;

	logic [KIND_W-1:0] kind_q;
	logic [MW-1:0]     mem_q;
	logic [TW-1:0]     tin_q;
	logic [TW-1:0]     team_rd;
	logic [TW-1:0]     ring_rd;
	logic [SW-1:0]     head_rd, tail_rd, link_rd, free_rd;
	logic [MW-1:0]     smem_rd;
	logic [TW-1:0]     team_q;

	assign clr_done = clr_q[MW];
	assign busy = (state_q != S_IDLE) || !clr_done;

	// slot from the free stack: untouched entries hold their own index
	logic [SW-1:0] slot_new;
	assign slot_new = (used_q < freeinit_q) ? free_rd : used_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clr_q <= '0;
			used_q <= '0;
			freeinit_q <= '0;
			ohead_q <= '0;
			otail_q <= '0;
			ocnt_q <= '0;
			nonempty_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (!clr_done) clr_q <= clr_q + 1'b1;
			unique case (state_q)
				S_IDLE: if (start && clr_done) state_q <= S_RD;
				S_RD: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_RD4;
				S_RD4: state_q <= S_WR;
				S_WR: begin
					state_q <= S_IDLE;
					done <= 1'b1;
					if (kind_q == KIND_ENQUEUE && used_q < CW'(SLOTS)) begin
						used_q <= used_q + 1'b1;
						if (!nonempty_q[team_q]) begin
							nonempty_q[team_q] <= 1'b1;
							otail_q <= (otail_q == TW'(MAX_TEAMS - 1)) ? '0 : otail_q + 1'b1;
							ocnt_q <= ocnt_q + 1'b1;
						end
					end else if (kind_q == KIND_DEQUEUE && ocnt_q != '0) begin
						if (head_rd == tail_rd) begin
							nonempty_q[team_q] <= 1'b0;
							ohead_q <= (ohead_q == TW'(MAX_TEAMS - 1)) ? '0 : ohead_q + 1'b1;
							ocnt_q <= ocnt_q - 1'b1;
						end
						if (used_q != '0) begin
							used_q <= used_q - 1'b1;
							if (used_q > freeinit_q) freeinit_q <= used_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operands and read stages
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			kind_q <= kind;
			mem_q <= MW'(member_id % MAX_MEMBERS);
			tin_q <= TW'(team_id % MAX_TEAMS);
		end
		team_rd <= mteam_mem[mem_q];
		ring_rd <= ring_mem[ohead_q];
		free_rd <= free_mem[used_q[SW-1:0]];
		if (state_q == S_RD2)
			team_q <= (kind_q == KIND_ENQUEUE) ? team_rd : ring_rd;
		head_rd <= thead_mem[team_q];
		tail_rd <= ttail_mem[team_q];
	end

	always_ff @(posedge clk) begin
		smem_rd <= smem_mem[head_rd];
		link_rd <= slink_mem[head_rd];
	end

	// writes
	always_ff @(posedge clk) begin
		if (!clr_done)
			mteam_mem[clr_q[MW-1:0]] <= '0;
		else if (state_q == S_WR && kind_q == KIND_ASSIGN)
			mteam_mem[mem_q] <= tin_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WR && kind_q == KIND_ENQUEUE && used_q < CW'(SLOTS)) begin
			smem_mem[slot_new] <= mem_q;
			if (nonempty_q[team_q])
				slink_mem[tail_rd] <= slot_new;
			else begin
				thead_mem[team_q] <= slot_new;
				ring_mem[otail_q] <= team_q;
			end
			ttail_mem[team_q] <= slot_new;
		end else if (state_q == S_WR && kind_q == KIND_DEQUEUE && ocnt_q != '0) begin
			if (head_rd != tail_rd) thead_mem[team_q] <= link_rd;
			if (used_q != '0) free_mem[SW'(used_q - 1'b1)] <= head_rd;
		end
	end

	// result needs smem_rd which lands in S_WR after head_rd settles in S_RD4
	always_ff @(posedge clk) begin
		if (state_q == S_WR) begin
			res.member <= '0;
			res.status <= ST_OK;
			if (kind_q == KIND_ENQUEUE && used_q >= CW'(SLOTS)) res.status <= ST_FULL;
			if (kind_q == KIND_DEQUEUE) begin
				if (ocnt_q == '0) res.status <= ST_EMPTY;
				else res.member <= MEMBER_W'(smem_rd);
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/team_grouped_fifo_queue.sv -----
// team queue: members grouped by team, served team after team
// input channel in_valid/in_stall carries kind, member_id, team_id;
// kind 0 maps a member to a team, 1 enqueues a member, 2 dequeues
// output channel out_valid/out_stall carries out_member and status, one
// beat for every input beat, in order
// the core runs a sequence of dependent synchronous-memory reads (member
// table or team ring, then team head/tail, then slot memory) followed by a
// write-back state
// one item is processed at a time, so a new input beat is taken only once
// the core has finished the last one; the result sits in an output register
// so the next beat can be taken while the receiver stalls, but a further
// result waits in the core and holds in_stall high until that register is free
// after reset the member table is cleared by a sweep over all its entries,
// during which in_stall stays high
// a stalled output beat holds its payload unchanged
`default_nettype none
module team_grouped_fifo_queue
	import tgfq_pkg::*;
#(
	parameter int MAX_TEAMS   = MAX_TEAMS_D,
	parameter int MAX_MEMBERS = MAX_MEMBERS_D,
	parameter int SLOTS       = SLOTS_D
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [MEMBER_W-1:0] member_id,
	input  wire logic [TEAM_W-1:0]   team_id,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [MEMBER_W-1:0]      out_member,
	output logic [STATUS_W-1:0]      status
);
	logic    busy, done, start;
	result_t res;
	logic    pend_q; // core result not yet moved to output

	// accept only when core idle and no core result waiting
	assign in_stall = busy || pend_q || (done && out_valid && out_stall);
	assign start = in_valid && !in_stall;

	tgfq_core #(
		.MAX_TEAMS(MAX_TEAMS), .MAX_MEMBERS(MAX_MEMBERS), .SLOTS(SLOTS)
	) u_core (
		.clk, .arst_n, .start, .kind, .member_id, .team_id,
		.busy, .done, .res
	);

	// output register; res stays stable until the next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if ((done || pend_q) && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
				pend_q <= 1'b0;
			end else if (done) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((done || pend_q) && (!out_valid || !out_stall)) begin
			out_member <= res.member;
			status <= res.status;
		end
	end

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("start while core busy");
	a_done_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !pend_q)
		else $error("result overrun");
	a_pend_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !start)
		else $error("accept with pending result");
endmodule
`default_nettype wire
